[hw/rtl/fat_pkg.sv]
package fat_pkg;

    localparam int BOARDS_DEF   = 12;
    localparam int CHANNELS_DEF = 18;
    localparam int EXPECTED_DEF = 216;

    localparam int ID_W      = 29;
    localparam int CHAN_W    = 8;
    localparam int BOARD_W   = 5;
    localparam int BOARD_LSB = 18;

    // covers BOARDS * CHANNELS up to 1024 slots
    localparam int SLOT_W   = 10;
    localparam int ROW_BITS = 32;
    localparam int BIT_W    = 5;

    localparam int COUNT_W = 8;
    localparam int INDEX_W = 8;
    localparam int EXP_W   = 11;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic REG_FIRST_BOARD = 1'b0;
    localparam logic [BOARD_W-1:0] FIRST_BOARD_RST = 5'd1;

    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 24;

    typedef enum logic [2:0] {
        ST_NEW       = 3'd0,
        ST_REPEAT    = 3'd1,
        ST_BAD_BOARD = 3'd2,
        ST_BAD_CHAN  = 3'd3,
        ST_CLEARED   = 3'd4
    } status_t;

    typedef enum logic {
        MODE_FRAME = 1'b0,
        MODE_CLEAR = 1'b1
    } mode_t;

    typedef struct packed {
        logic              clear;
        logic              bad_board;
        logic              bad_chan;
        logic [SLOT_W-1:0] slot;
    } dec_t;

    typedef struct packed {
        logic rd_en;
        logic wr_en;
        logic clr;
    } map_ctl_t;

endpackage

[hw/rtl/frame_arrival_tracker_top.sv]
// frame arrival tracker
// s_ channel: one transaction per frame or clear command; s_tuser carries the
// mode (frame or clear), s_tdata the identifier and the 1-based channel number.
// m_ channel: one result transaction per input transaction, in order; m_tuser
// holds the status code, m_tdata the slot, the running count and the complete
// flag. first_board_id is set through the apb port; the user must set it only
// while the block is idle, which the block itself does not enforce.
// each input item is held in the lookup stage register, then in the result register.
// throughput: one item per cycle while m_tready is high; the received bitmap lives
// in a memory of 32-bit rows and each frame does one row read and, if new, one
// write-back, with the row forwarded when consecutive frames hit the same row.
// reset clears per-row valid bits at once, so the bitmap reads empty with no
// clearing pass; a clear item empties it the same way.
// when m_tready is low the result register holds, one more item may enter
// the lookup stage, and s_tready then drops until the result is taken.
module frame_arrival_tracker_top #(
    parameter int BOARDS          = fat_pkg::BOARDS_DEF,
    parameter int CHANNELS        = fat_pkg::CHANNELS_DEF,
    parameter int EXPECTED_FRAMES = fat_pkg::EXPECTED_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [fat_pkg::PADDR_W-1:0]       paddr,
    input  logic [fat_pkg::PDATA_W-1:0]       pwdata,
    output logic [fat_pkg::PDATA_W-1:0]       prdata,
    output logic                              pready,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // [28:0] can_identifier, [36:29] channel_number, [39:37] zero
    input  logic [fat_pkg::S_TDATA_W-1:0]     s_tdata,
    // [0] mode
    input  logic                              s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [7:0] frame_index, [15:8] frames_received, [16] all_received, [23:17] zero
    output logic [fat_pkg::M_TDATA_W-1:0]     m_tdata,
    // [2:0] status
    output logic [2:0]                        m_tuser
);
    import fat_pkg::*;

    localparam logic [EXP_W-1:0] EXPECTED_L = EXP_W'(EXPECTED_FRAMES);

    logic [BOARD_W-1:0] first_board;
    dec_t               dec;
    map_ctl_t           map_ctl;
    logic               seen;

    logic               s_accept;
    logic               out_free;
    logic               adv;

    logic               p1_valid_reg;
    logic               p1_valid_next;
    dec_t               p1_dec_reg;

    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;
    logic               complete_reg;
    logic               complete_next;
    logic [COUNT_W-1:0] count_inc;

    logic               m_valid_reg;
    logic               m_valid_next;
    status_t            status_reg;
    status_t            status_next;
    logic [INDEX_W-1:0] index_reg;
    logic [INDEX_W-1:0] index_next;
    logic [COUNT_W-1:0] out_count_reg;
    logic               out_all_reg;
    logic               is_new;

    fat_cfg u_cfg (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .first_board (first_board)
    );

    fat_decode #(
        .BOARDS   (BOARDS),
        .CHANNELS (CHANNELS)
    ) u_decode (
        .mode           (s_tuser),
        .can_identifier (s_tdata[ID_W-1:0]),
        .channel_number (s_tdata[ID_W +: CHAN_W]),
        .first_board    (first_board),
        .dec            (dec)
    );

    fat_map #(
        .BOARDS   (BOARDS),
        .CHANNELS (CHANNELS)
    ) u_map (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctl       (map_ctl),
        .rd_slot   (dec.slot),
        .look_slot (p1_dec_reg.slot),
        .seen      (seen)
    );

    assign out_free = !m_valid_reg || m_tready;
    assign adv      = p1_valid_reg && out_free;
    assign s_tready = !p1_valid_reg || out_free;
    assign s_accept = s_tvalid && s_tready;

    assign is_new = !p1_dec_reg.clear && !p1_dec_reg.bad_board
                    && !p1_dec_reg.bad_chan && !seen;

    assign map_ctl.rd_en = s_accept && !dec.clear && !dec.bad_board && !dec.bad_chan;
    assign map_ctl.wr_en = adv && is_new;
    assign map_ctl.clr   = adv && p1_dec_reg.clear;

    assign count_inc = (count_reg == COUNT_MAX) ? count_reg : count_reg + COUNT_W'(1);

    always_comb begin
        count_next    = count_reg;
        complete_next = complete_reg;
        status_next   = status_reg;
        index_next    = index_reg;
        if (adv) begin
            priority if (p1_dec_reg.clear) begin
                count_next    = '0;
                complete_next = 1'b0;
                status_next   = ST_CLEARED;
                index_next    = '0;
            end else if (p1_dec_reg.bad_board) begin
                status_next = ST_BAD_BOARD;
                index_next  = '0;
            end else if (p1_dec_reg.bad_chan) begin
                status_next = ST_BAD_CHAN;
                index_next  = '0;
            end else if (seen) begin
                status_next = ST_REPEAT;
                index_next  = p1_dec_reg.slot[INDEX_W-1:0];
            end else begin
                count_next    = count_inc;
                complete_next = complete_reg || (EXP_W'(count_inc) >= EXPECTED_L);
                status_next   = ST_NEW;
                index_next    = p1_dec_reg.slot[INDEX_W-1:0];
            end
        end
    end

    always_comb begin
        p1_valid_next = p1_valid_reg;
        if (s_accept) begin
            p1_valid_next = 1'b1;
        end else if (adv) begin
            p1_valid_next = 1'b0;
        end
        m_valid_next = m_valid_reg;
        if (adv) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            count_reg    <= '0;
            complete_reg <= 1'b0;
        end else begin
            p1_valid_reg <= p1_valid_next;
            m_valid_reg  <= m_valid_next;
            count_reg    <= count_next;
            complete_reg <= complete_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            p1_dec_reg <= dec;
        end
        if (adv) begin
            status_reg    <= status_next;
            index_reg     <= index_next;
            out_count_reg <= count_next;
            out_all_reg   <= complete_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = status_reg;
    assign m_tdata  = M_TDATA_W'({out_all_reg, out_count_reg, index_reg});

`ifndef SYNTH
    a_complete_drops_on_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        ($fell(complete_reg) && $past(aresetn)) |-> $past(adv && p1_dec_reg.clear))
        else $error("complete flag dropped without a clear item");

    a_count_steps_by_one: assert property (@(posedge aclk) disable iff (!aresetn)
        ((count_reg != $past(count_reg)) && $past(aresetn))
        |-> ((count_reg == '0) || (count_reg == COUNT_W'($past(count_reg) + 1'b1))))
        else $error("frame count changed by more than one");

    a_stall_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (p1_valid_reg && m_valid_reg && !m_tready) |-> !s_tready)
        else $error("input accepted with both stages full and output stalled");
`endif

endmodule

[hw/rtl/fat_cfg.sv]
module fat_cfg (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [fat_pkg::PADDR_W-1:0]   paddr,
    input  logic [fat_pkg::PDATA_W-1:0]   pwdata,
    output logic [fat_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready,
    output logic [fat_pkg::BOARD_W-1:0]   first_board
);
    import fat_pkg::*;

    logic [BOARD_W-1:0] first_board_reg;
    logic [BOARD_W-1:0] first_board_next;
    logic               reg_sel;

    assign reg_sel = (paddr[PADDR_W-1] == REG_FIRST_BOARD);
    assign pready  = 1'b1;

    always_comb begin
        first_board_next = first_board_reg;
        if (psel && penable && pwrite && pready && reg_sel) begin
            first_board_next = pwdata[BOARD_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            first_board_reg <= FIRST_BOARD_RST;
        end else begin
            first_board_reg <= first_board_next;
        end
    end

    assign prdata      = reg_sel ? PDATA_W'(first_board_reg) : '0;
    assign first_board = first_board_reg;

endmodule

[hw/rtl/fat_decode.sv]
module fat_decode #(
    parameter int BOARDS   = fat_pkg::BOARDS_DEF,
    parameter int CHANNELS = fat_pkg::CHANNELS_DEF
) (
    input  logic                         mode,
    input  logic [fat_pkg::ID_W-1:0]     can_identifier,
    input  logic [fat_pkg::CHAN_W-1:0]   channel_number,
    input  logic [fat_pkg::BOARD_W-1:0]  first_board,
    output fat_pkg::dec_t                dec
);
    import fat_pkg::*;

    localparam int BW1 = BOARD_W + 1;
    localparam logic [BW1-1:0]    BOARDS_L   = BW1'(BOARDS);
    localparam logic [CHAN_W-1:0] CHANNELS_L = CHAN_W'(CHANNELS);
    localparam logic [SLOT_W-1:0] CHANNELS_S = SLOT_W'(CHANNELS);

    logic [BOARD_W-1:0] board;
    logic [BOARD_W-1:0] board_off;
    logic               in_window;
    logic               chan_ok;

    assign board     = can_identifier[BOARD_LSB +: BOARD_W];
    assign board_off = board - first_board;
    // window end may pass 31, so compare the offset rather than the sum
    assign in_window = (board >= first_board) && ({1'b0, board_off} < BOARDS_L);
    assign chan_ok   = (channel_number != '0) && (channel_number <= CHANNELS_L);

    always_comb begin
        dec.clear     = (mode_t'(mode) == MODE_CLEAR);
        dec.bad_board = !in_window;
        dec.bad_chan  = !chan_ok;
        dec.slot      = SLOT_W'(board_off) * CHANNELS_S + SLOT_W'(channel_number)
                        - SLOT_W'(1);
    end

endmodule

[hw/rtl/fat_map.sv]
module fat_map #(
    parameter int BOARDS   = fat_pkg::BOARDS_DEF,
    parameter int CHANNELS = fat_pkg::CHANNELS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  fat_pkg::map_ctl_t             ctl,
    input  logic [fat_pkg::SLOT_W-1:0]    rd_slot,
    input  logic [fat_pkg::SLOT_W-1:0]    look_slot,
    output logic                          seen
);
    import fat_pkg::*;

    localparam int SLOTS = BOARDS * CHANNELS;
    localparam int ROWS  = (SLOTS + ROW_BITS - 1) / ROW_BITS;
    localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;

    logic [ROW_BITS-1:0] mem [ROWS];
    logic [ROW_BITS-1:0] rdata_reg;
    logic [ROWS-1:0]     row_vld_reg;
    logic [ROWS-1:0]     row_vld_next;
    logic                fwd_reg;
    logic [ROW_BITS-1:0] fwd_data_reg;

    logic [SLOT_W-BIT_W-1:0] rd_row_full;
    logic [SLOT_W-BIT_W-1:0] wr_row_full;
    logic [ROW_W-1:0]        rd_row;
    logic [ROW_W-1:0]        wr_row;
    logic [BIT_W-1:0]        wr_bit;
    logic [ROW_BITS-1:0]     row_cur;
    logic [ROW_BITS-1:0]     wdata;

    assign rd_row_full = rd_slot[SLOT_W-1:BIT_W];
    assign wr_row_full = look_slot[SLOT_W-1:BIT_W];
    assign rd_row      = rd_row_full[ROW_W-1:0];
    assign wr_row      = wr_row_full[ROW_W-1:0];
    assign wr_bit      = look_slot[BIT_W-1:0];

    // a row not written since the last clear reads as empty
    always_comb begin
        if (fwd_reg) begin
            row_cur = fwd_data_reg;
        end else if (row_vld_reg[wr_row]) begin
            row_cur = rdata_reg;
        end else begin
            row_cur = '0;
        end
    end

    assign seen  = row_cur[wr_bit];
    assign wdata = row_cur | (ROW_BITS'(1) << wr_bit);

    always_comb begin
        row_vld_next = row_vld_reg;
        if (ctl.clr) begin
            row_vld_next = '0;
        end else if (ctl.wr_en) begin
            row_vld_next[wr_row] = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_vld_reg <= '0;
            fwd_reg     <= 1'b0;
        end else begin
            row_vld_reg <= row_vld_next;
            if (ctl.rd_en) begin
                // write-back to the row being read: memory returns old data
                fwd_reg <= ctl.wr_en && (rd_row == wr_row);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.rd_en) begin
            rdata_reg    <= mem[rd_row];
            fwd_data_reg <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.wr_en) begin
            mem[wr_row] <= wdata;
        end
    end

`ifndef SYNTH
    a_no_clr_with_write: assert property (@(posedge aclk) disable iff (!aresetn)
        !(ctl.clr && ctl.wr_en))
        else $error("bitmap clear and write in the same cycle");

    a_write_sets_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.wr_en |=> row_vld_reg[$past(wr_row)])
        else $error("written row not marked valid");
`endif

endmodule
